// File: rtl/edp_pkg.sv
// edp_pkg: shared types and constants for the event de-duplicating packetizer
// no dependencies
package edp_pkg;

    localparam int unsigned WORD_BITS = 64;
    localparam int unsigned CNT_BITS  = 5;
    localparam int unsigned WIN_BITS  = 16;
    localparam int unsigned TICK_BITS = 32;

    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic REG_NEAR_WINDOW = 1'b0;
    localparam logic REG_FLUSH_TICKS = 1'b1;

    localparam logic [WIN_BITS-1:0]  NEAR_WINDOW_RST = 16'd20;
    localparam logic [TICK_BITS-1:0] FLUSH_TICKS_RST = 32'd100000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STORE,
        ST_EMIT
    } t_back_state;

endpackage

// File: rtl/edp_if.sv
// edp_if: valid/ready channel interfaces
// depends on edp_pkg
interface edp_in_if import edp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [WORD_BITS-1:0] word0;
    logic [WORD_BITS-1:0] word1;
    logic [WORD_BITS-1:0] word2;
    modport source (output valid, command, word0, word1, word2, input ready);
    modport sink   (input valid, command, word0, word1, word2, output ready);
endinterface

interface edp_out_if import edp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] out_word0;
    logic [WORD_BITS-1:0] out_word1;
    logic [WORD_BITS-1:0] out_word2;
    logic [CNT_BITS-1:0]  events_in_packet;
    logic                 last_in_packet;
    modport source (output valid, out_word0, out_word1, out_word2, events_in_packet,
                    last_in_packet, input ready);
    modport sink   (input valid, out_word0, out_word1, out_word2, events_in_packet,
                    last_in_packet, output ready);
endinterface

interface edp_cfg_if import edp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 index;
    logic [TICK_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/edp_front.sv
// edp_front: input queue between the accepting side and the back end
// depends on edp_pkg
module edp_front import edp_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_command,
    input  logic [WORD_BITS-1:0] i_word0,
    input  logic [WORD_BITS-1:0] i_word1,
    input  logic [WORD_BITS-1:0] i_word2,
    output logic                 o_valid,
    input  logic                 i_pop,
    output logic                 o_command,
    output logic [WORD_BITS-1:0] o_word0,
    output logic [WORD_BITS-1:0] o_word1,
    output logic [WORD_BITS-1:0] o_word2
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 r_cmd [DEPTH];
    logic [WORD_BITS-1:0] r_w0  [DEPTH];
    logic [WORD_BITS-1:0] r_w1  [DEPTH];
    logic [WORD_BITS-1:0] r_w2  [DEPTH];
    logic [AW-1:0]        r_wp, r_rp, n_wp, n_rp;
    logic [AW:0]          r_cnt;
    logic                 push, pop;

    assign o_ready = (r_cnt != DEPTH[AW:0]);
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= n_wp;
            if (pop)  r_rp <= n_rp;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_cmd[r_wp] <= i_command;
            r_w0[r_wp]  <= i_word0;
            r_w1[r_wp]  <= i_word1;
            r_w2[r_wp]  <= i_word2;
        end
    end

    assign o_command = r_cmd[r_rp];
    assign o_word0   = r_w0[r_rp];
    assign o_word1   = r_w1[r_rp];
    assign o_word2   = r_w2[r_rp];
endmodule

// File: rtl/edp_back.sv
// edp_back: history scan, packet buffer, tick counting and packet emission
// depends on edp_pkg
module edp_back import edp_pkg::*; #(
    parameter int unsigned HISTORY_DEPTH = 80,
    parameter int unsigned PACKET_EVENTS = 20,
    parameter int unsigned COUNTER_BITS  = 55
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [WIN_BITS-1:0]  i_near_window,
    input  logic [TICK_BITS-1:0] i_flush_ticks,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  logic                 i_command,
    input  logic [WORD_BITS-1:0] i_word0,
    input  logic [WORD_BITS-1:0] i_word1,
    input  logic [WORD_BITS-1:0] i_word2,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_BITS-1:0] o_word0,
    output logic [WORD_BITS-1:0] o_word1,
    output logic [WORD_BITS-1:0] o_word2,
    output logic [CNT_BITS-1:0]  o_count,
    output logic                 o_last,
    output logic                 o_idle
);
    localparam int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned HC = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned PW = (PACKET_EVENTS > 1) ? $clog2(PACKET_EVENTS) : 1;
    localparam int unsigned PC = $clog2(PACKET_EVENTS + 1);

    logic [COUNTER_BITS-1:0] r_hist [HISTORY_DEPTH];
    logic [3*WORD_BITS-1:0]  r_pkt  [PACKET_EVENTS];

    t_back_state             r_state, n_state;
    logic [HW-1:0]           r_head;
    logic [HC-1:0]           r_idx;
    logic [HC-1:0]           r_hvalid;
    logic [PC-1:0]           r_fill, r_emit;
    logic [TICK_BITS-1:0]    r_ticks;
    logic [COUNTER_BITS-1:0] r_ctr, r_hrd;
    logic                    r_rdv, r_near;
    logic [3*WORD_BITS-1:0]  r_ev, r_prd;
    logic                    r_ovalid, r_olast, r_pvalid;
    logic [CNT_BITS-1:0]     r_ocnt;
    logic [COUNTER_BITS-1:0] ctr_in, diff;
    logic [PW-1:0]           slot;
    logic                    tick_flush, ob_free;

    assign ctr_in = i_word0[COUNTER_BITS-1:0];
    assign diff   = (r_ctr > r_hrd) ? r_ctr - r_hrd : r_hrd - r_ctr;
    assign slot   = r_fill[PW-1:0];
    assign tick_flush = (((r_ticks == '1) ? r_ticks : r_ticks + 1'b1) >= i_flush_ticks)
                        && (r_fill != '0);
    assign ob_free = !r_ovalid || i_ready;
    assign o_pop   = (r_state == ST_IDLE) && i_valid;
    assign o_idle  = (r_state == ST_IDLE) && !r_ovalid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_TICK) n_state = tick_flush ? ST_EMIT : ST_IDLE;
                    else if (ctr_in != '0) n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_near) n_state = ST_IDLE;
                else if (!r_rdv && r_idx >= r_hvalid) n_state = ST_STORE;
            end
            ST_STORE: n_state = (r_fill + 1'b1 >= PC'(PACKET_EVENTS)) ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (r_emit == r_fill && !r_pvalid) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_hvalid <= '0;
            r_fill   <= '0;
            r_ticks  <= '0;
            r_idx    <= '0;
            r_emit   <= '0;
            r_rdv    <= 1'b0;
            r_near   <= 1'b0;
            r_pvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ob_free) r_ovalid <= (r_state == ST_EMIT) && r_pvalid;
            unique case (r_state)
                ST_IDLE: begin
                    r_idx  <= '0;
                    r_emit <= '0;
                    r_rdv  <= 1'b0;
                    r_near <= 1'b0;
                    r_pvalid <= 1'b0;
                    if (i_valid && i_command == CMD_TICK && r_ticks != '1)
                        r_ticks <= r_ticks + 1'b1;
                end
                ST_SCAN: begin
                    if (r_rdv && diff < COUNTER_BITS'(i_near_window)) r_near <= 1'b1;
                    if (r_idx < r_hvalid && !r_near) begin
                        r_rdv <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                    end
                end
                ST_STORE: begin
                    r_head <= (r_head == HW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    if (r_hvalid != HC'(HISTORY_DEPTH)) r_hvalid <= r_hvalid + 1'b1;
                    r_fill <= r_fill + 1'b1;
                end
                ST_EMIT: begin
                    if (r_pvalid && ob_free) begin
                        r_olast  <= (r_emit == r_fill);
                        r_ocnt   <= CNT_BITS'(r_fill);
                    end
                    if (r_emit != r_fill && (!r_pvalid || ob_free)) begin
                        r_pvalid <= 1'b1;
                        r_emit   <= r_emit + 1'b1;
                    end else if (ob_free) begin
                        r_pvalid <= 1'b0;
                    end
                    if (r_emit == r_fill && !r_pvalid) begin
                        r_fill  <= '0;
                        r_ticks <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_ctr <= ctr_in;
            r_ev  <= {i_word2, i_word1, i_word0};
        end
        r_hrd <= r_hist[r_idx[HW-1:0]];
        if (r_state == ST_STORE) begin
            r_hist[r_head] <= r_ctr;
            r_pkt[slot]    <= r_ev;
        end
        if (r_state == ST_EMIT && (!r_pvalid || ob_free)) r_prd <= r_pkt[r_emit[PW-1:0]];
        if (r_state == ST_EMIT && r_pvalid && ob_free) begin
            o_word0 <= r_prd[WORD_BITS-1:0];
            o_word1 <= r_prd[2*WORD_BITS-1:WORD_BITS];
            o_word2 <= r_prd[3*WORD_BITS-1:2*WORD_BITS];
        end
    end

    assign o_valid = r_ovalid;
    assign o_count = r_ocnt;
    assign o_last  = r_olast;
endmodule

// File: rtl/event_dedup_packetizer_core.sv
// channel      | dir | payload
// i_in         | in  | command, word0..2
// o_out        | out | out_word0..2, events_in_packet, last_in_packet
// i_cfg        | in  | index, data
// an event with a nonzero counter walks the history one read at a time, then is stored or dropped;
// a flush reads the packed events out one after another through the buffer read port
// a tick without flush returns straight to idle; a two-entry queue holds arrivals meanwhile
// synchronous active-low reset clears control; stores are not cleared
// output stalls hold the back end, input stalls only fill the queue
module event_dedup_packetizer_core import edp_pkg::*; #(
    parameter int unsigned HISTORY_DEPTH = 80,
    parameter int unsigned PACKET_EVENTS = 20,
    parameter int unsigned COUNTER_BITS  = 55
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    edp_in_if.sink    i_in,
    edp_out_if.source o_out,
    edp_cfg_if.sink   i_cfg
);
    logic                 q_valid, q_pop, q_cmd, b_idle;
    logic [WORD_BITS-1:0] q_w0, q_w1, q_w2;
    logic [WIN_BITS-1:0]  r_near_window;
    logic [TICK_BITS-1:0] r_flush_ticks;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_window <= NEAR_WINDOW_RST;
            r_flush_ticks <= FLUSH_TICKS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_NEAR_WINDOW: r_near_window <= i_cfg.data[WIN_BITS-1:0];
                REG_FLUSH_TICKS: r_flush_ticks <= i_cfg.data;
                default: ;
            endcase
        end
    end

    edp_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in.valid), .o_ready(i_in.ready), .i_command(i_in.command),
        .i_word0(i_in.word0), .i_word1(i_in.word1), .i_word2(i_in.word2),
        .o_valid(q_valid), .i_pop(q_pop), .o_command(q_cmd),
        .o_word0(q_w0), .o_word1(q_w1), .o_word2(q_w2)
    );

    edp_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH), .PACKET_EVENTS(PACKET_EVENTS),
        .COUNTER_BITS(COUNTER_BITS)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_near_window(r_near_window), .i_flush_ticks(r_flush_ticks),
        .i_valid(q_valid), .o_pop(q_pop), .i_command(q_cmd),
        .i_word0(q_w0), .i_word1(q_w1), .i_word2(q_w2),
        .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_word0(o_out.out_word0), .o_word1(o_out.out_word1), .o_word2(o_out.out_word2),
        .o_count(o_out.events_in_packet), .o_last(o_out.last_in_packet),
        .o_idle(b_idle)
    );

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.events_in_packet != '0) else $error("empty packet count");
    a_pop_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_idle |-> !o_out.valid) else $error("output while idle");
endmodule

// File: dv/tb_edp_scoreboard.sv
// tb_edp_scoreboard: expected-packet predictor and result checker for the packetizer
// depends on edp_pkg
package tb_edp_scoreboard_pkg;
    import edp_pkg::*;

    typedef struct packed {
        logic [WORD_BITS-1:0] w0;
        logic [WORD_BITS-1:0] w1;
        logic [WORD_BITS-1:0] w2;
        logic [CNT_BITS-1:0]  count;
        logic                 last;
    } t_packed_event;

    class edp_scoreboard;
        localparam int HIST = 80;
        localparam int PKT  = 20;
        logic [54:0]          seen_ctr[HIST];
        int                   hist_slot;
        int                   hist_fill;
        logic [WORD_BITS-1:0] pkt_words[PKT][3];
        int                   pkt_fill;
        logic [31:0]          tick_count;
        logic [15:0]          window;
        logic [31:0]          flush_after;
        t_packed_event        pending[$];
        int                   errors;

        function new();
            hist_slot = 0; hist_fill = 0; pkt_fill = 0; tick_count = 0;
            window = NEAR_WINDOW_RST; flush_after = FLUSH_TICKS_RST; errors = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] data);
            if (idx == REG_NEAR_WINDOW) window = data[15:0];
            else flush_after = data;
        endfunction

        function void flush_packet();
            t_packed_event e;
            for (int k = 0; k < pkt_fill; k++) begin
                e.w0 = pkt_words[k][0]; e.w1 = pkt_words[k][1]; e.w2 = pkt_words[k][2];
                e.count = pkt_fill[CNT_BITS-1:0];
                e.last = (k + 1 == pkt_fill);
                pending.push_back(e);
            end
            pkt_fill = 0;
            tick_count = 0;
        endfunction

        function void note_input(logic cmd, logic [63:0] a, logic [63:0] b, logic [63:0] c);
            logic [54:0] ctr;
            logic [54:0] d;
            bit dup;
            if (cmd == CMD_TICK) begin
                if (tick_count != 32'hFFFF_FFFF) tick_count++;
                if (tick_count >= flush_after && pkt_fill > 0) flush_packet();
                return;
            end
            ctr = a[54:0];
            dup = (ctr == 0);
            for (int j = 0; j < hist_fill; j++) begin
                d = (ctr > seen_ctr[j]) ? ctr - seen_ctr[j] : seen_ctr[j] - ctr;
                if (d < {39'd0, window}) dup = 1;
            end
            if (dup) return;
            seen_ctr[hist_slot] = ctr;
            hist_slot = (hist_slot + 1) % HIST;
            if (hist_fill < HIST) hist_fill++;
            pkt_words[pkt_fill][0] = a; pkt_words[pkt_fill][1] = b; pkt_words[pkt_fill][2] = c;
            pkt_fill++;
            if (pkt_fill >= PKT) flush_packet();
        endfunction

        task automatic report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task automatic check_result(t_packed_event got);
            t_packed_event exp;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            exp = pending.pop_front();
            if (got.w0 !== exp.w0) report($sformatf("word0 %h exp %h", got.w0, exp.w0));
            if (got.w1 !== exp.w1) report($sformatf("word1 %h exp %h", got.w1, exp.w1));
            if (got.w2 !== exp.w2) report($sformatf("word2 %h exp %h", got.w2, exp.w2));
            if (got.count !== exp.count)
                report($sformatf("count %0d exp %0d", got.count, exp.count));
            if (got.last !== exp.last) report($sformatf("last %b exp %b", got.last, exp.last));
        endtask
    endclass
endpackage

// File: dv/tb_event_dedup_packetizer_core.sv
// tb_event_dedup_packetizer_core: random and directed test of the packetizer core
// depends on edp_pkg, edp_if and tb_edp_scoreboard
module tb_event_dedup_packetizer_core;
    import edp_pkg::*;
    import tb_edp_scoreboard_pkg::*;

    logic i_clk;
    logic i_rst_n;
    edp_in_if  in_ch();
    edp_out_if out_ch();
    edp_cfg_if cfg_ch();

    event_dedup_packetizer_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    edp_scoreboard sb;
    int unsigned cycles;
    int unsigned stall_mode;
    logic [54:0] base_ctr;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3_000_000) begin
            $display("tb_event_dedup_packetizer_core NOT OK");
            $finish;
        end
    end

    // receiver stall pattern, changed per phase
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 0;
        else case (stall_mode)
            0: out_ch.ready <= 1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= (cycles[3:0] < 5);
            default: out_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_packed_event r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            r.w0 = out_ch.out_word0; r.w1 = out_ch.out_word1; r.w2 = out_ch.out_word2;
            r.count = out_ch.events_in_packet; r.last = out_ch.last_in_packet;
            sb.check_result(r);
        end
    end

    task automatic send(logic cmd, logic [63:0] a, logic [63:0] b, logic [63:0] c);
        in_ch.valid <= 1; in_ch.command <= cmd;
        in_ch.word0 <= a; in_ch.word1 <= b; in_ch.word2 <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(cmd, a, b, c);
    endtask

    task automatic pause();
        in_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // an event with no flush may still be walking the history
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // fresh counter well apart from all earlier fresh ones, random upper bits
    function automatic logic [63:0] fresh_event();
        logic [63:0] w;
        base_ctr = base_ctr + 55'd70000 + $urandom_range(0, 1000);
        w = rnd64();
        w[54:0] = base_ctr;
        return w;
    endfunction

    task automatic random_phase(int n, int near_pct);
        int burst;
        logic [63:0] w;
        int k;
        k = 0;
        while (k < n) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                case ($urandom_range(0, 99) < near_pct ? 1 : ($urandom_range(0, 5) == 0 ? 2 : 0))
                    0: w = fresh_event();
                    1: begin
                        w = rnd64();
                        w[54:0] = base_ctr + $urandom_range(0, 40) - 20;
                    end
                    default: begin
                        w = rnd64();
                        if ($urandom_range(0, 3) == 0) w[54:0] = 0;
                    end
                endcase
                if ($urandom_range(0, 4) == 0) send(CMD_TICK, rnd64(), rnd64(), rnd64());
                else send(CMD_EVENT, w, rnd64(), rnd64());
                k++;
            end
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) pause();
        end
    endtask

    initial begin
        logic [63:0] w;
        in_ch.valid = 0; in_ch.command = CMD_EVENT;
        in_ch.word0 = 0; in_ch.word1 = 0; in_ch.word2 = 0;
        cfg_ch.valid = 0; cfg_ch.index = REG_NEAR_WINDOW; cfg_ch.data = 0;
        stall_mode = 0; base_ctr = 55'd1000;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        // directed: zero counter, duplicate, extremes, tick flush
        write_reg(REG_FLUSH_TICKS, 32'd2);
        send(CMD_EVENT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send(CMD_EVENT, 64'hFF80_0000_0000_0000, 64'h1, 64'h2);
        send(CMD_EVENT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send(CMD_EVENT, 64'h007F_FFFF_FFFF_FFF0, 64'h0, 64'h0);
        send(CMD_EVENT, 64'h0000_0000_0000_0001, 64'hA5A5, 64'h5A5A);
        send(CMD_EVENT, 64'h0000_0000_0000_0014, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send(CMD_EVENT, 64'h0000_0000_0000_0015, 64'h3, 64'h4);
        send(CMD_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0);
        send(CMD_TICK, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send(CMD_TICK, 64'h0, 64'h0, 64'h0);
        drain();

        // full packet flush with window at its top
        write_reg(REG_NEAR_WINDOW, 32'h0000_FFFF);
        write_reg(REG_FLUSH_TICKS, 32'hFFFF_FFFF);
        stall_mode = 1;
        for (int i = 0; i < 21; i++) begin
            w = fresh_event();
            send(CMD_EVENT, w, rnd64(), rnd64());
        end
        drain();

        // window of one: neighbouring counters accepted
        write_reg(REG_NEAR_WINDOW, 32'd1);
        write_reg(REG_FLUSH_TICKS, 32'd1);
        base_ctr = base_ctr + 55'd100000;
        for (int i = 0; i < 3; i++) begin
            w = rnd64(); w[54:0] = base_ctr + i;
            send(CMD_EVENT, w, rnd64(), rnd64());
        end
        send(CMD_TICK, 64'h0, 64'h0, 64'h0);
        drain();

        stall_mode = 2;
        write_reg(REG_NEAR_WINDOW, 32'd20);
        write_reg(REG_FLUSH_TICKS, 32'd3);
        random_phase(90, 15);
        drain();

        stall_mode = 3;
        write_reg(REG_NEAR_WINDOW, 32'd300);
        write_reg(REG_FLUSH_TICKS, 32'd1);
        random_phase(70, 20);
        drain();

        stall_mode = 0;
        write_reg(REG_NEAR_WINDOW, 32'd5);
        write_reg(REG_FLUSH_TICKS, 32'd8);
        random_phase(64, 10);
        send(CMD_TICK, 64'h0, 64'h0, 64'h0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_event_dedup_packetizer_core OK");
        else
            $display("tb_event_dedup_packetizer_core NOT OK");
        $finish;
    end
endmodule
